FILE: src/ttt_pkg.sv
// shared types and constants for the two-tier transposition table
package ttt_pkg;

    localparam int INDEX_BITS = 12;
    localparam int SLOT_COUNT = 1 << INDEX_BITS;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_STORE  = 1'b1;

    typedef logic [INDEX_BITS-1:0] t_slot;

    typedef struct packed {
        logic [63:0]        key;
        logic [6:0]         depth;
        logic signed [15:0] eval;
        logic [1:0]         ntype;
        logic [15:0]        move;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    typedef struct packed {
        logic               kind;
        logic [63:0]        position_hash;
        logic [6:0]         depth_in;
        logic signed [15:0] eval_in;
        logic [1:0]         node_type_in;
        logic [15:0]        best_move_in;
        logic               best_move_given;
    } t_req;

endpackage

FILE: src/ttt_req_if.sv
// request channel of the transposition table
interface ttt_req_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [63:0]        position_hash;
    logic [6:0]         depth_in;
    logic signed [15:0] eval_in;
    logic [1:0]         node_type_in;
    logic [15:0]        best_move_in;
    logic               best_move_given;

    modport source (
        output valid, kind, position_hash, depth_in, eval_in, node_type_in,
               best_move_in, best_move_given,
        input  ready
    );
    modport sink (
        input  valid, kind, position_hash, depth_in, eval_in, node_type_in,
               best_move_in, best_move_given,
        output ready
    );
endinterface

FILE: src/ttt_rsp_if.sv
// lookup result channel of the transposition table
interface ttt_rsp_if;
    logic               valid;
    logic               ready;
    logic               eval_hit;
    logic signed [15:0] eval_out;
    logic [1:0]         node_type_out;
    logic               move_hit;
    logic [15:0]        best_move_out;

    modport source (
        output valid, eval_hit, eval_out, node_type_out, move_hit, best_move_out,
        input  ready
    );
    modport sink (
        input  valid, eval_hit, eval_out, node_type_out, move_hit, best_move_out,
        output ready
    );
endinterface

FILE: src/ttt_ram.sv
// simple dual-port ram with one write port and one registered read port
module ttt_ram #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [(1 << ADDR_BITS)];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/two_tier_transposition_table_unit.sv
// top level of the two-tier transposition table
//
// Each request does a registered read of the slot (occupancy bit,
// depth-preferred entry and always-replace entry read in parallel from three
// memories), then a compare and write-back step. One request is in flight at
// a time, so a new one is taken only after the last has finished that step; a
// lookup waits there while the output register holds an untaken result. A
// finished lookup result sits in the output register, and the next request is
// taken while it waits. After reset a clearing pass zeroes the occupancy
// memory, and no request is accepted until it ends; writes of r_pv_code are
// taken at any time. Stores return nothing; each lookup returns one result.
module two_tier_transposition_table_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    ttt_req_if.sink    i_req,
    ttt_rsp_if.source  o_rsp
);

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } t_state;

    t_state           r_state;
    logic             r_clr_busy;
    ttt_pkg::t_slot   r_clr_addr;
    logic [1:0]       r_pv_code;
    ttt_pkg::t_req    r_req;

    logic               r_out_valid;
    logic               r_eval_hit;
    logic signed [15:0] r_eval_out;
    logic [1:0]         r_node_type_out;
    logic               r_move_hit;
    logic [15:0]        r_best_move_out;

    logic               accept;
    logic               out_free;
    logic               step_done;
    logic               is_store;
    logic               n_out_valid;
    ttt_pkg::t_slot     rd_slot;
    ttt_pkg::t_slot     wr_slot;
    logic               used_rdata;
    logic [ttt_pkg::ENTRY_BITS-1:0] deep_rdata;
    logic [ttt_pkg::ENTRY_BITS-1:0] recent_rdata;
    ttt_pkg::t_entry    deep_e;
    ttt_pkg::t_entry    recent_e;
    ttt_pkg::t_entry    new_e;
    logic               used_we;
    ttt_pkg::t_slot     used_waddr;
    logic               deep_we;
    logic               recent_we;

    logic               deep_eval_ok;
    logic               recent_eval_ok;
    logic               deep_move_ok;
    logic               recent_move_ok;
    logic               n_eval_hit;
    logic signed [15:0] n_eval_out;
    logic [1:0]         n_node_type_out;
    logic               n_move_hit;
    logic [15:0]        n_best_move_out;

    assign i_req.ready = (r_state == S_IDLE) && !r_clr_busy;
    assign accept      = i_req.valid && i_req.ready;
    assign rd_slot     = i_req.position_hash[ttt_pkg::INDEX_BITS-1:0];
    assign wr_slot     = r_req.position_hash[ttt_pkg::INDEX_BITS-1:0];

    assign out_free  = !r_out_valid || o_rsp.ready;
    assign is_store  = (r_req.kind == ttt_pkg::KIND_STORE);
    assign step_done = (r_state == S_EVAL) && (is_store || out_free);

    // a finished lookup loads the output register, otherwise it drains on ready
    assign n_out_valid = (step_done && !is_store) || (r_out_valid && !o_rsp.ready);

    assign deep_e   = ttt_pkg::t_entry'(deep_rdata);
    assign recent_e = ttt_pkg::t_entry'(recent_rdata);

    always_comb begin
        new_e.key   = r_req.position_hash;
        new_e.depth = r_req.depth_in;
        new_e.eval  = r_req.eval_in;
        new_e.ntype = r_req.node_type_in;
        new_e.move  = r_req.best_move_given ? r_req.best_move_in : 16'd0;
    end

    // store placement: empty slot fills both tiers, deeper search wins the deep tier
    always_comb begin
        deep_we   = 1'b0;
        recent_we = 1'b0;
        if (step_done && is_store) begin
            if (!used_rdata) begin
                deep_we   = 1'b1;
                recent_we = 1'b1;
            end else if (r_req.depth_in > deep_e.depth) begin
                deep_we   = 1'b1;
            end else begin
                recent_we = 1'b1;
            end
        end
    end

    assign used_we    = r_clr_busy || (step_done && is_store && !used_rdata);
    assign used_waddr = r_clr_busy ? r_clr_addr : wr_slot;

    // lookup answers, depth-preferred tier first
    always_comb begin
        deep_eval_ok   = (deep_e.key == r_req.position_hash)
                         && (r_req.depth_in <= deep_e.depth);
        recent_eval_ok = (recent_e.key == r_req.position_hash)
                         && (r_req.depth_in <= recent_e.depth);
        deep_move_ok   = (deep_e.key == r_req.position_hash) && (deep_e.ntype == r_pv_code);
        recent_move_ok = (recent_e.key == r_req.position_hash)
                         && (recent_e.ntype == r_pv_code);
        n_eval_hit      = 1'b0;
        n_eval_out      = 16'sd0;
        n_node_type_out = 2'd0;
        n_move_hit      = 1'b0;
        n_best_move_out = 16'd0;
        if (used_rdata) begin
            if (deep_eval_ok) begin
                n_eval_hit      = 1'b1;
                n_eval_out      = deep_e.eval;
                n_node_type_out = deep_e.ntype;
            end else if (recent_eval_ok) begin
                n_eval_hit      = 1'b1;
                n_eval_out      = recent_e.eval;
                n_node_type_out = recent_e.ntype;
            end
            if (deep_move_ok) begin
                n_move_hit      = 1'b1;
                n_best_move_out = deep_e.move;
            end else if (recent_move_ok) begin
                n_move_hit      = 1'b1;
                n_best_move_out = recent_e.move;
            end
        end
    end

    ttt_ram #(.WIDTH(1), .ADDR_BITS(ttt_pkg::INDEX_BITS)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (used_waddr),
        .i_wdata (!r_clr_busy),
        .i_re    (accept),
        .i_raddr (rd_slot),
        .o_rdata (used_rdata)
    );

    ttt_ram #(.WIDTH(ttt_pkg::ENTRY_BITS), .ADDR_BITS(ttt_pkg::INDEX_BITS)) u_deep_ram (
        .i_clk   (i_clk),
        .i_we    (deep_we),
        .i_waddr (wr_slot),
        .i_wdata (new_e),
        .i_re    (accept),
        .i_raddr (rd_slot),
        .o_rdata (deep_rdata)
    );

    ttt_ram #(.WIDTH(ttt_pkg::ENTRY_BITS), .ADDR_BITS(ttt_pkg::INDEX_BITS)) u_recent_ram (
        .i_clk   (i_clk),
        .i_we    (recent_we),
        .i_waddr (wr_slot),
        .i_wdata (new_e),
        .i_re    (accept),
        .i_raddr (rd_slot),
        .o_rdata (recent_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv_code <= 2'd0;
        end else if (i_cfg_we) begin
            r_pv_code <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.kind            <= i_req.kind;
            r_req.position_hash   <= i_req.position_hash;
            r_req.depth_in        <= i_req.depth_in;
            r_req.eval_in         <= i_req.eval_in;
            r_req.node_type_in    <= i_req.node_type_in;
            r_req.best_move_in    <= i_req.best_move_in;
            r_req.best_move_given <= i_req.best_move_given;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (step_done) begin
                        r_state <= S_IDLE;
                        if (!is_store) begin
                            r_eval_hit      <= n_eval_hit;
                            r_eval_out      <= n_eval_out;
                            r_node_type_out <= n_node_type_out;
                            r_move_hit      <= n_move_hit;
                            r_best_move_out <= n_best_move_out;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.eval_hit      = r_eval_hit;
    assign o_rsp.eval_out      = r_eval_out;
    assign o_rsp.node_type_out = r_node_type_out;
    assign o_rsp.move_hit      = r_move_hit;
    assign o_rsp.best_move_out = r_best_move_out;

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the two-tier transposition table
module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;
    localparam int HOT_SLOTS   = 6;
    localparam int HOT_KEYS    = 18;

    typedef struct packed {
        logic               eval_hit;
        logic signed [15:0] eval_out;
        logic [1:0]         node_type_out;
        logic               move_hit;
        logic [15:0]        best_move_out;
    } t_probe_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;

    ttt_req_if req_if ();
    ttt_rsp_if rsp_if ();

    two_tier_transposition_table_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // shadow copy of the table
    bit               tbl_used   [ttt_pkg::SLOT_COUNT];
    ttt_pkg::t_entry  tbl_deep   [ttt_pkg::SLOT_COUNT];
    ttt_pkg::t_entry  tbl_recent [ttt_pkg::SLOT_COUNT];
    logic [1:0]       pv_code = 2'd0;

    t_probe_result pending_lookups [$];
    logic [63:0]   hot_keys [HOT_KEYS];

    int          error_count  = 0;
    int          result_count = 0;
    int          cycle_count  = 0;
    bit          idling_on    = 1'b0;
    int unsigned hold_request = 0;
    int unsigned hold_left    = 0;
    int unsigned stall_left   = 0;

    always #5 i_clk = ~i_clk;

    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idling_on || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic ttt_pkg::t_req make_req(input logic kind, input logic [63:0] hash,
                                               input logic [6:0] depth,
                                               input logic [15:0] eval,
                                               input logic [1:0] ntype,
                                               input logic [15:0] move,
                                               input logic given);
        ttt_pkg::t_req r;
        r.kind            = kind;
        r.position_hash   = hash;
        r.depth_in        = depth;
        r.eval_in         = eval;
        r.node_type_in    = ntype;
        r.best_move_in    = move;
        r.best_move_given = given;
        return r;
    endfunction

    // apply one accepted request to the shadow table, queue the lookup answer
    function automatic void apply_to_table(input ttt_pkg::t_req r);
        ttt_pkg::t_slot  s;
        ttt_pkg::t_entry e;
        ttt_pkg::t_entry d;
        ttt_pkg::t_entry c;
        t_probe_result   res;
        s = r.position_hash[ttt_pkg::INDEX_BITS-1:0];
        if (r.kind == ttt_pkg::KIND_STORE) begin
            e.key   = r.position_hash;
            e.depth = r.depth_in;
            e.eval  = r.eval_in;
            e.ntype = r.node_type_in;
            e.move  = r.best_move_given ? r.best_move_in : 16'h0000;
            if (tbl_used[s]) begin
                if (e.depth > tbl_deep[s].depth) begin
                    tbl_deep[s] = e;
                end else begin
                    tbl_recent[s] = e;
                end
            end else begin
                tbl_deep[s]   = e;
                tbl_recent[s] = e;
                tbl_used[s]   = 1'b1;
            end
        end else begin
            res = '0;
            if (tbl_used[s]) begin
                d = tbl_deep[s];
                c = tbl_recent[s];
                if (d.key == r.position_hash && r.depth_in <= d.depth) begin
                    res.eval_hit      = 1'b1;
                    res.eval_out      = d.eval;
                    res.node_type_out = d.ntype;
                end else if (c.key == r.position_hash && r.depth_in <= c.depth) begin
                    res.eval_hit      = 1'b1;
                    res.eval_out      = c.eval;
                    res.node_type_out = c.ntype;
                end
                if (d.key == r.position_hash && d.ntype == pv_code) begin
                    res.move_hit      = 1'b1;
                    res.best_move_out = d.move;
                end else if (c.key == r.position_hash && c.ntype == pv_code) begin
                    res.move_hit      = 1'b1;
                    res.best_move_out = c.move;
                end
            end
            pending_lookups.push_back(res);
        end
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= 10) begin
                $display("lookup result %0d %s: expected %h, got %h",
                         result_count, name, want, got);
            end
        end
    endtask

    // request side: predict every accepted request and track config writes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) pv_code = i_cfg_wdata;
            if (req_if.valid && req_if.ready) begin
                apply_to_table(make_req(req_if.kind, req_if.position_hash,
                                        req_if.depth_in, req_if.eval_in,
                                        req_if.node_type_in, req_if.best_move_in,
                                        req_if.best_move_given));
            end
        end
    end

    // result side: check each lookup answer against the oldest prediction
    always @(posedge i_clk) begin
        t_probe_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            result_count++;
            if (pending_lookups.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("lookup result %0d arrived with no lookup pending", result_count);
                end
            end else begin
                want = pending_lookups.pop_front();
                compare_field("eval_hit", 16'(want.eval_hit), 16'(rsp_if.eval_hit));
                compare_field("eval_out", want.eval_out, rsp_if.eval_out);
                compare_field("node_type_out", 16'(want.node_type_out),
                              16'(rsp_if.node_type_out));
                compare_field("move_hit", 16'(want.move_hit), 16'(rsp_if.move_hit));
                compare_field("best_move_out", want.best_move_out, rsp_if.best_move_out);
            end
        end
    end

    // result ready: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            stall_left = idle_cycles();
            rsp_if.ready <= (stall_left == 0);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: errors");
        $finish;
    end

    // valid stays high between back-to-back requests
    task automatic send_req(input ttt_pkg::t_req item);
        int unsigned gap;
        gap = idle_cycles();
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid           <= 1'b1;
        req_if.kind            <= item.kind;
        req_if.position_hash   <= item.position_hash;
        req_if.depth_in        <= item.depth_in;
        req_if.eval_in         <= item.eval_in;
        req_if.node_type_in    <= item.node_type_in;
        req_if.best_move_in    <= item.best_move_in;
        req_if.best_move_given <= item.best_move_given;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic settle_table();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_lookups.size() != 0) @(posedge i_clk);
        // a trailing store may still be writing back
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pv_code(input logic [1:0] code);
        settle_table();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // a few slots, three keys each, so entries collide and get evicted
    task automatic refresh_hot_keys();
        logic [63:0]    rnd;
        ttt_pkg::t_slot slot;
        for (int i = 0; i < HOT_KEYS; i++) begin
            if (i % (HOT_KEYS / HOT_SLOTS) == 0) begin
                slot = ttt_pkg::t_slot'($urandom_range(0, ttt_pkg::SLOT_COUNT - 1));
            end
            rnd = {$urandom, $urandom};
            hot_keys[i] = {rnd[63:ttt_pkg::INDEX_BITS], slot};
        end
    endtask

    function automatic logic [6:0] random_depth();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 7'($urandom_range(0, 15));
        if (r < 80) return 7'd0;
        if (r < 90) return 7'd127;
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic ttt_pkg::t_req random_item();
        ttt_pkg::t_req r;
        int unsigned   pick;
        int unsigned   ev;
        logic [63:0]   rnd;
        pick = $urandom_range(0, 99);
        ev   = $urandom_range(0, 99);
        rnd  = {$urandom, $urandom};
        r.kind          = (pick < 45) ? ttt_pkg::KIND_STORE : ttt_pkg::KIND_LOOKUP;
        r.position_hash = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
        if (pick >= 85 && pick < 93) begin
            // used slot, foreign key
            r.position_hash[63:ttt_pkg::INDEX_BITS] = rnd[63:ttt_pkg::INDEX_BITS];
        end else if (pick >= 93) begin
            r.position_hash = rnd;
        end
        r.depth_in        = random_depth();
        r.eval_in         = (ev < 10) ? 16'sh8000 : (ev < 20) ? 16'sh7FFF : 16'($urandom);
        r.node_type_in    = 2'($urandom_range(0, 3));
        r.best_move_in    = 16'($urandom);
        r.best_move_given = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic test_directed_cases();
        logic [63:0] ka;
        logic [63:0] kb;
        logic [63:0] kc;
        ka = 64'h0123_4567_89AB_C001;
        kb = 64'hFEDC_BA98_7654_3001;
        kc = 64'hFFFF_FFFF_FFFF_FFFF;
        idling_on = 1'b0;
        write_pv_code(2'd0);
        // empty slots at both ends of the index range
        send_req(make_req(ttt_pkg::KIND_LOOKUP, 64'h0, 7'd0, 16'h0, 2'd0, 16'h0, 1'b0));
        send_req(make_req(ttt_pkg::KIND_LOOKUP, kc, 7'd127, 16'hFFFF, 2'd3, 16'hFFFF, 1'b1));
        // first store fills both tiers
        send_req(make_req(ttt_pkg::KIND_STORE, ka, 7'd10, 16'h8000, 2'd0, 16'hFFFF, 1'b1));
        send_req(make_req(ttt_pkg::KIND_LOOKUP, ka, 7'd10, 16'h0, 2'd0, 16'h0, 1'b0));
        send_req(make_req(ttt_pkg::KIND_LOOKUP, ka, 7'd11, 16'h0, 2'd0, 16'h0, 1'b0));
        send_req(make_req(ttt_pkg::KIND_LOOKUP, kb, 7'd0, 16'h0, 2'd0, 16'h0, 1'b0));
        // equal depth goes to the always-replace tier, move not given
        send_req(make_req(ttt_pkg::KIND_STORE, ka, 7'd10, 16'h7FFF, 2'd1, 16'h1234, 1'b0));
        send_req(make_req(ttt_pkg::KIND_LOOKUP, ka, 7'd0, 16'h0, 2'd0, 16'h0, 1'b0));
        // deeper store takes the depth-preferred tier
        send_req(make_req(ttt_pkg::KIND_STORE, ka, 7'd127, 16'h0005, 2'd2, 16'hABCD, 1'b1));
        send_req(make_req(ttt_pkg::KIND_LOOKUP, ka, 7'd127, 16'h0, 2'd0, 16'h0, 1'b0));
        // colliding key lands in the always-replace tier
        send_req(make_req(ttt_pkg::KIND_STORE, kb, 7'd0, 16'hFFFF, 2'd0, 16'h0000, 1'b1));
        send_req(make_req(ttt_pkg::KIND_LOOKUP, kb, 7'd0, 16'h0, 2'd0, 16'h0, 1'b0));
        send_req(make_req(ttt_pkg::KIND_LOOKUP, kb, 7'd1, 16'h0, 2'd0, 16'h0, 1'b0));
        send_req(make_req(ttt_pkg::KIND_LOOKUP, ka, 7'd0, 16'h0, 2'd0, 16'h0, 1'b0));
        send_req(make_req(ttt_pkg::KIND_STORE, kc, 7'd127, 16'h7FFF, 2'd3, 16'hFFFF, 1'b1));
        send_req(make_req(ttt_pkg::KIND_LOOKUP, kc, 7'd127, 16'h0, 2'd0, 16'h0, 1'b0));
        send_req(make_req(ttt_pkg::KIND_LOOKUP, kc, 7'd0, 16'h7FFF, 2'd3, 16'hFFFF, 1'b1));
        write_pv_code(2'd3);
        send_req(make_req(ttt_pkg::KIND_LOOKUP, kc, 7'd0, 16'h0, 2'd0, 16'h0, 1'b0));
        send_req(make_req(ttt_pkg::KIND_LOOKUP, ka, 7'd0, 16'h0, 2'd0, 16'h0, 1'b0));
    endtask

    task automatic test_random_traffic(input logic [1:0] code, input bit with_idling,
                                       input int count);
        write_pv_code(code);
        idling_on = with_idling;
        refresh_hot_keys();
        for (int i = 0; i < count; i++) send_req(random_item());
    endtask

    // results back up while the sender keeps offering requests
    task automatic test_result_hold_off();
        write_pv_code(2'd2);
        idling_on = 1'b0;
        refresh_hot_keys();
        hold_request = 300;
        for (int i = 0; i < 60; i++) send_req(random_item());
    endtask

    initial begin
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_wdata            = 2'd0;
        req_if.valid           = 1'b0;
        req_if.kind            = ttt_pkg::KIND_LOOKUP;
        req_if.position_hash   = '0;
        req_if.depth_in        = '0;
        req_if.eval_in         = '0;
        req_if.node_type_in    = '0;
        req_if.best_move_in    = '0;
        req_if.best_move_given = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic(2'd1, 1'b1, 350);
        test_random_traffic(2'd2, 1'b0, 350);
        test_result_hold_off();
        test_random_traffic(2'd0, 1'b1, 350);
        test_random_traffic(2'd3, 1'b1, 350);

        settle_table();
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

FILE: two_tier_transposition_table_unit.f
src/ttt_pkg.sv
src/ttt_req_if.sv
src/ttt_rsp_if.sv
src/ttt_ram.sv
src/two_tier_transposition_table_unit.sv
verif/testbench.sv
